[design/f2e_pkg.sv]
// Shared types and constants of the frame-to-event pixel model.
// Used by the controller, the datapath, the top level and the checker; depends on nothing.
package f2e_pkg;

  localparam int unsigned IMAGE_WIDTH_DEF  = 256;
  localparam int unsigned IMAGE_HEIGHT_DEF = 256;
  localparam logic [7:0]  THRESHOLD_RESET  = 8'd15;
  localparam logic [7:0]  MIN_THRESHOLD    = 8'd4;
  localparam int unsigned DIV_STEPS        = 16;
  localparam logic [15:0] TIME_MAX         = 16'hFFFF;

  // One input pixel sample.
  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] gray_value;
  } px_in_t;

  // One output event.
  typedef struct packed {
    logic [7:0]  event_x;
    logic [7:0]  event_y;
    logic        event_on;
    logic [15:0] event_time;
    logic        last_event;
  } px_evt_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic mem_rd;
    logic wr_first;
    logic wr_keep;
    logic load;
    logic calc;
    logic div_step;
    logic emit;
  } f2e_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_range;
    logic clear_done;
    logic seen;
    logic below_thr;
    logic div_last;
    logic out_free;
    logic last_cross;
  } f2e_status_t;

endpackage

[design/f2e_ctrl.sv]
// Controller state machine of the frame-to-event pixel model.
// Depends on f2e_pkg for the command and status structs.
module f2e_ctrl
  import f2e_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  f2e_status_t status_i,
  output f2e_cmd_t    cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_CALC  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.in_range) state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        if (!status_i.seen) begin
          cmd_o.wr_first = 1'b1;
          state_d        = ST_IDLE;
        end else if (status_i.below_thr) begin
          cmd_o.wr_keep = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.load = 1'b1;
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.last_cross ? ST_IDLE : ST_CALC;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/f2e_datapath.sv]
// Datapath of the frame-to-event pixel model: pixel state memory, crossing
// stepper, serial time divider, threshold register and output register.
// Depends on f2e_pkg.
module f2e_datapath
  import f2e_pkg::*;
#(
  parameter int unsigned IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int unsigned IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  px_in_t      in_data_i,
  input  logic        cfg_valid_i,
  input  logic [7:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output px_evt_t     out_data_o,
  input  f2e_cmd_t    cmd_i,
  output f2e_status_t status_o
);

  localparam int unsigned STORE_COLS  = (IMAGE_WIDTH < 256) ? IMAGE_WIDTH : 256;
  localparam int unsigned STORE_DEPTH = STORE_COLS * IMAGE_HEIGHT;
  localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned IDX_W       = 21;
  localparam int unsigned CNT_W       = $clog2(DIV_STEPS);

  logic [7:0]        thr_q;
  logic [7:0]        thr_eff;
  logic [7:0]        x_q, y_q, v_q, p_q, c_q, rem_q, divr_q, den_q;
  logic              pol_q, need_div_q;
  logic [15:0]       time_q, quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ADDR_W-1:0] addr_q, clr_q;
  logic [16:0]       mem [STORE_DEPTH];
  logic [16:0]       rd_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [16:0]       mem_wd;
  logic [IDX_W-1:0]  idx;
  logic [7:0]        ref_lvl, prev_lvl, lvl_gap;
  logic              up;
  logic [8:0]        num, den;
  logic [7:0]        an, ad;
  logic              zero_t, sat_t;
  logic [8:0]        rem2;
  logic              ge;
  px_evt_t           out_q;
  logic              out_valid_q;
  logic              last;

  assign thr_eff = (thr_q < MIN_THRESHOLD) ? MIN_THRESHOLD : thr_q;

  // Threshold register, written through the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // Pixel address and image bounds check.
  assign idx = IDX_W'(in_data_i.pixel_x) * IDX_W'(IMAGE_HEIGHT) + IDX_W'(in_data_i.pixel_y);
  assign status_o.in_range = (13'(in_data_i.pixel_x) < 13'(IMAGE_WIDTH)) &&
                             (13'(in_data_i.pixel_y) < 13'(IMAGE_HEIGHT));

  // Stored state of the current pixel.
  assign ref_lvl   = rd_q[15:8];
  assign prev_lvl  = rd_q[7:0];
  assign up        = v_q > ref_lvl;
  assign lvl_gap   = up ? (v_q - ref_lvl) : (ref_lvl - v_q);
  assign status_o.seen      = rd_q[16];
  assign status_o.below_thr = lvl_gap < thr_eff;

  // Fraction operands of the current crossing.
  assign num    = {1'b0, c_q} - {1'b0, p_q};
  assign den    = {1'b0, v_q} - {1'b0, p_q};
  assign an     = num[8] ? 8'(-num) : num[7:0];
  assign ad     = den[8] ? 8'(-den) : den[7:0];
  assign zero_t = (den == '0) || (num == '0) || (num[8] != den[8]);
  assign sat_t  = an >= ad;

  // One restoring division step.
  assign rem2 = {divr_q, 1'b0};
  assign ge   = rem2 >= {1'b0, den_q};

  assign last                = rem_q < thr_eff;
  assign status_o.last_cross = last;
  assign status_o.div_last   = !need_div_q || (cnt_q == CNT_W'(DIV_STEPS - 1));
  assign status_o.clear_done = clr_q == ADDR_W'(STORE_DEPTH - 1);

  // Sample registers, crossing stepper and divider.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q    <= in_data_i.pixel_x;
      y_q    <= in_data_i.pixel_y;
      v_q    <= in_data_i.gray_value;
      addr_q <= idx[ADDR_W-1:0];
    end
    if (cmd_i.load) begin
      pol_q <= up;
      p_q   <= prev_lvl;
      c_q   <= up ? (ref_lvl + thr_eff) : (ref_lvl - thr_eff);
      rem_q <= lvl_gap - thr_eff;
    end
    if (cmd_i.calc) begin
      need_div_q <= !(zero_t || sat_t);
      time_q     <= zero_t ? '0 : TIME_MAX;
      divr_q     <= an;
      den_q      <= ad;
      quo_q      <= '0;
      cnt_q      <= '0;
    end
    if (cmd_i.div_step && need_div_q) begin
      divr_q <= ge ? 8'(rem2 - {1'b0, den_q}) : rem2[7:0];
      quo_q  <= {quo_q[14:0], ge};
      cnt_q  <= cnt_q + 1'b1;
    end
    if (cmd_i.emit && !last) begin
      c_q   <= pol_q ? (c_q + thr_eff) : (c_q - thr_eff);
      rem_q <= rem_q - thr_eff;
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Memory write selection: {seen, reference, previous}.
  always_comb begin
    mem_we = 1'b1;
    mem_wa = addr_q;
    mem_wd = {1'b1, c_q, v_q};
    if (cmd_i.clr_wr) begin
      mem_wa = clr_q;
      mem_wd = '0;
    end else if (cmd_i.wr_first) begin
      mem_wd = {1'b1, v_q, v_q};
    end else if (cmd_i.wr_keep) begin
      mem_wd = {1'b1, ref_lvl, v_q};
    end else if (!(cmd_i.emit && last)) begin
      mem_we = 1'b0;
    end
  end

  // Pixel state memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd_i.mem_rd) rd_q <= mem[addr_q];
  end

  // Output register.
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.event_x    <= x_q;
      out_q.event_y    <= y_q;
      out_q.event_on   <= pol_q;
      out_q.event_time <= need_div_q ? quo_q : time_q;
      out_q.last_event <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[design/frame_to_event_pixel_model_top.sv]
// Flow: a sample outside the image is accepted and dropped; any other sample is accepted,
// its state is read and a decision is made, then each event takes setup, the 16-step
// serial divider (bypassed when the event time is zero or saturated) and emit, which waits
// while the output is stalled. Throughput: one sample at a time; the next is taken once the
// last event is in the output register. Reset starts a clearing pass of one store entry per
// cycle over min(IMAGE_WIDTH, 256) * IMAGE_HEIGHT entries. Uses f2e_pkg, f2e_ctrl, f2e_datapath.
module frame_to_event_pixel_model_top
  import f2e_pkg::*;
#(
  parameter int unsigned IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int unsigned IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  px_in_t     in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output px_evt_t    out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  f2e_cmd_t    cmd;
  f2e_status_t status;

  assign cfg_ready_o = 1'b1;

  f2e_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  f2e_datapath #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

[design/f2e_checker.sv]
// Port-level checks of the frame-to-event pixel model, bound to the top level.
// Depends on f2e_pkg and frame_to_event_pixel_model_top.
module f2e_checker
  import f2e_pkg::*;
#(
  parameter int unsigned IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int unsigned IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input px_in_t     in_data_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input px_evt_t    out_data_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o
);

  // A stalled event holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled event changed");

  // No new request is taken while a burst still has events to come.
  a_burst_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_event |-> in_stall_o)
    else $error("request taken in the middle of a burst");

  // An in-range request starts work and blocks the next one.
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (13'(in_data_i.pixel_x) < 13'(IMAGE_WIDTH)) &&
    (13'(in_data_i.pixel_y) < 13'(IMAGE_HEIGHT)) |=> in_stall_o)
    else $error("in-range request did not start work");

  // Configuration writes are always taken.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind frame_to_event_pixel_model_top f2e_checker #(
  .IMAGE_WIDTH  (IMAGE_WIDTH),
  .IMAGE_HEIGHT (IMAGE_HEIGHT)
) u_f2e_checker (.*);
